### sv/sbs_pkg.sv
// Shared types and constants for the solar brightness scheduler.
// No dependencies; compiled first.
`default_nettype none

package sbs_pkg;

    // Field widths
    localparam int MIN_W      = 11;
    localparam int HLT_W      = 2;
    localparam int LVL_W      = 8;
    localparam int SUN_W      = 14;
    localparam int FADE_W     = 8;
    localparam int CMP_W      = 16;
    localparam int PROD_W     = 2 * LVL_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int DIV_CNT_W  = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SUNRISE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUNSET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DAY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DFLT    = 3'd5;

    // Register reset values (-6000 in 14-bit two's complement)
    localparam logic [SUN_W-1:0]  RST_SUN   = 14'h2890;
    localparam logic [FADE_W-1:0] RST_FADE  = 8'd30;
    localparam logic [LVL_W-1:0]  RST_DAY   = 8'd255;
    localparam logic [LVL_W-1:0]  RST_NIGHT = 8'd10;
    localparam logic [LVL_W-1:0]  RST_DFLT  = 8'd128;

    // Health codes
    localparam logic [HLT_W-1:0] HEALTH_WARN = 2'd1;
    localparam logic [HLT_W-1:0] HEALTH_CRIT = 2'd2;

    localparam logic [LVL_W-1:0] CRIT_CAP = 8'd15;

    // Divider runs one quotient bit per cycle over the full product width
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_CNT = 4'(PROD_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_MUL,
        S_DIV,
        S_FIN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic classify;
        logic mul;
        logic div_step;
        logic fin_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_ramp;
        logic div_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

### sv/sbs_req_if.sv
// Request channel: minute of day and health code.
// Depends on sbs_pkg.
`default_nettype none

interface sbs_req_if;
    import sbs_pkg::*;

    logic             valid;
    logic             ready;
    logic [MIN_W-1:0] minute_of_day;
    logic [HLT_W-1:0] health;

    modport source (output valid, output minute_of_day, output health, input ready);
    modport sink   (input valid, input minute_of_day, input health, output ready);
endinterface

`default_nettype wire

### sv/sbs_rsp_if.sv
// Result channel: backlight level, night flag and change flag.
// Depends on sbs_pkg.
`default_nettype none

interface sbs_rsp_if;
    import sbs_pkg::*;

    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] level;
    logic             night;
    logic             changed;

    modport source (output valid, output level, output night, output changed, input ready);
    modport sink   (input valid, input level, input night, input changed, output ready);
endinterface

`default_nettype wire

### sv/sbs_dp.sv
// Datapath: config registers, period classifier, ramp multiply, serial
// divider, health override and output register. Depends on sbs_pkg.
`default_nettype none

module sbs_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [sbs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [sbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire [sbs_pkg::MIN_W-1:0]     i_minute_of_day,
    input  wire [sbs_pkg::HLT_W-1:0]     i_health,
    input  sbs_pkg::t_dp_cmd             i_cmd,
    output sbs_pkg::t_dp_sts             o_sts,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [sbs_pkg::LVL_W-1:0]    o_level,
    output logic                         o_night,
    output logic                         o_changed
);
    import sbs_pkg::*;

    // Configuration registers
    logic [SUN_W-1:0]  r_sunrise;
    logic [SUN_W-1:0]  r_sunset;
    logic [FADE_W-1:0] r_fade;
    logic [LVL_W-1:0]  r_day;
    logic [LVL_W-1:0]  r_night;
    logic [LVL_W-1:0]  r_dflt;

    // Request and working registers
    logic [MIN_W-1:0]     r_min;
    logic [HLT_W-1:0]     r_health;
    logic                 r_ramp;
    logic                 r_neg;
    logic                 r_night_flag;
    logic [LVL_W-1:0]     r_from;
    logic [LVL_W-1:0]     r_diff;
    logic [LVL_W-1:0]     r_pos;
    logic [LVL_W-1:0]     r_rem;
    logic [PROD_W-1:0]    r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [LVL_W-1:0]     r_applied;
    logic                 r_out_valid;
    logic [LVL_W-1:0]     r_out_level;
    logic                 r_out_night;
    logic                 r_out_changed;

    logic signed [CMP_W-1:0] w_m, w_s, w_t, w_f;
    logic signed [CMP_W-1:0] w_rise_pos, w_set_pos;
    logic                    w_fade_on, w_rise, w_day, w_set;
    logic [LVL_W-1:0]        w_to, w_from, w_pos;
    logic [LVL_W:0]          w_trial, w_sub;
    logic                    w_ge;
    logic [LVL_W-1:0]        w_q, w_solar, w_level;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sunrise <= RST_SUN;
            r_sunset  <= RST_SUN;
            r_fade    <= RST_FADE;
            r_day     <= RST_DAY;
            r_night   <= RST_NIGHT;
            r_dflt    <= RST_DFLT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SUNRISE: r_sunrise <= i_cfg_data;
                REG_SUNSET:  r_sunset  <= i_cfg_data;
                REG_FADE:    r_fade    <= i_cfg_data[FADE_W-1:0];
                REG_DAY:     r_day     <= i_cfg_data[LVL_W-1:0];
                REG_NIGHT:   r_night   <= i_cfg_data[LVL_W-1:0];
                REG_DFLT:    r_dflt    <= i_cfg_data[LVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Period classification, all compares signed
    always_comb begin
        w_m        = signed'({{(CMP_W-MIN_W){1'b0}}, r_min});
        w_s        = signed'({{(CMP_W-SUN_W){r_sunrise[SUN_W-1]}}, r_sunrise});
        w_t        = signed'({{(CMP_W-SUN_W){r_sunset[SUN_W-1]}}, r_sunset});
        w_f        = signed'({{(CMP_W-FADE_W){1'b0}}, r_fade});
        w_fade_on  = (r_fade != '0);
        w_rise     = w_fade_on && (w_m >= w_s - w_f) && (w_m < w_s);
        w_day      = (w_m >= w_s) && (w_m < w_t);
        w_set      = w_fade_on && (w_m >= w_t) && (w_m < w_t + w_f);
        w_rise_pos = w_m - w_s + w_f;
        w_set_pos  = w_m - w_t;
        w_from     = r_night;
        w_to       = r_day;
        w_pos      = w_rise_pos[LVL_W-1:0];
        if (!w_rise && !w_day && w_set) begin
            w_from = r_day;
            w_to   = r_night;
            w_pos  = w_set_pos[LVL_W-1:0];
        end else if (!w_rise && w_day) begin
            w_from = r_day;
        end
    end

    // Restoring divide step: one quotient bit per cycle
    always_comb begin
        w_trial = {r_rem, r_quo[PROD_W-1]};
        w_sub   = w_trial - {1'b0, r_fade};
        w_ge    = (w_trial >= {1'b0, r_fade});
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_min    <= i_minute_of_day;
            r_health <= i_health;
        end
        if (i_cmd.classify) begin
            r_ramp       <= w_rise || (!w_day && w_set);
            r_night_flag <= !w_rise && !w_day && !w_set;
            r_from       <= w_from;
            r_neg        <= (w_to < w_from);
            r_diff       <= (w_to < w_from) ? (w_from - w_to) : (w_to - w_from);
            r_pos        <= w_pos;
        end
        if (i_cmd.mul) begin
            r_quo <= {{(PROD_W-LVL_W){1'b0}}, r_diff} * {{(PROD_W-LVL_W){1'b0}}, r_pos};
            r_rem <= '0;
            r_cnt <= DIV_LAST_CNT;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[PROD_W-2:0], w_ge};
            r_rem <= w_ge ? w_sub[LVL_W-1:0] : w_trial[LVL_W-1:0];
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    // Ramp result and health override
    always_comb begin
        w_q = r_quo[LVL_W-1:0];
        if (!r_ramp) begin
            w_solar = r_from;
        end else if (r_neg) begin
            w_solar = r_from - w_q;
        end else begin
            w_solar = r_from + w_q;
        end
        case (r_health)
            HEALTH_CRIT: begin
                w_level = (w_solar > CRIT_CAP) ? CRIT_CAP : w_solar;
            end
            HEALTH_WARN: begin
                w_level = r_dflt;
            end
            default: begin
                w_level = w_solar;
            end
        endcase
    end

    // Output register and applied level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_applied   <= '0;
        end else if (i_cmd.fin_load) begin
            r_out_valid <= 1'b1;
            r_applied   <= w_level;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_load) begin
            r_out_level   <= w_level;
            r_out_night   <= r_night_flag;
            r_out_changed <= (w_level != r_applied);
        end
    end

    assign o_sts.is_ramp  = r_ramp;
    assign o_sts.div_last = (r_cnt == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_level        = r_out_level;
    assign o_night        = r_out_night;
    assign o_changed      = r_out_changed;

    // A loaded result becomes the applied level
    a_applied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin_load |=> (r_applied == r_out_level))
        else $error("applied level differs from delivered level");

    // Critical health never delivers more than the cap
    a_crit_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fin_load && r_health == HEALTH_CRIT) |=> (r_out_level <= CRIT_CAP))
        else $error("critical health level above cap");

endmodule

`default_nettype wire

### sv/sbs_ctrl.sv
// Controller: sequences accept, classify, multiply, divide and output load.
// Depends on sbs_pkg.
`default_nettype none

module sbs_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  sbs_pkg::t_dp_sts i_sts,
    output sbs_pkg::t_dp_cmd o_cmd
);
    import sbs_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CLASS;
                end
            end
            S_CLASS: begin
                o_cmd.classify = 1'b1;
                n_state        = S_MUL;
            end
            S_MUL: begin
                if (i_sts.is_ramp) begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // An accepted request is classified in the next cycle
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CLASS))
        else $error("accepted request not classified");

    // The last divide step hands over to the output stage
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> (r_state == S_FIN))
        else $error("divider did not finish into output stage");

endmodule

`default_nettype wire

### sv/solar_brightness_scheduler.sv
// Solar brightness scheduler top level: controller plus datapath.
// Inside a fade ramp a request runs classify, multiply and the 16-step ramp divider,
// one quotient bit per cycle, before the output load; otherwise the divider is skipped.
// A new request is accepted only after the previous result has been loaded for output.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active low) restores config defaults and clears applied level.
`default_nettype none

module solar_brightness_scheduler (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    sbs_req_if.sink                       i_req_if,
    sbs_rsp_if.source                     o_rsp_if,
    input  wire                           i_cfg_we,
    input  wire [sbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [sbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sbs_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    sbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req_if.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sbs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_minute_of_day (i_req_if.minute_of_day),
        .i_health        (i_req_if.health),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_out_valid     (o_rsp_if.valid),
        .i_out_ready     (o_rsp_if.ready),
        .o_level         (o_rsp_if.level),
        .o_night         (o_rsp_if.night),
        .o_changed       (o_rsp_if.changed)
    );

    assign i_req_if.ready = w_in_ready;

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for solar_brightness_scheduler: directed and random requests,
// checked against an in-bench predictor of the backlight schedule.
// Depends on sbs_pkg, sbs_req_if, sbs_rsp_if and the scheduler RTL.
`timescale 1ns / 100ps

module testbench;
    import sbs_pkg::*;

    // Health codes with no override
    localparam logic [HLT_W-1:0] HEALTH_OK    = 2'd0;
    localparam logic [HLT_W-1:0] HEALTH_SPARE = 2'd3;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_CYC   = 30;
    localparam int PRINT_LIMIT  = 40;
    localparam int RAND_PHASES  = 14;
    localparam int PHASE_ITEMS  = 110;
    localparam int HOLD_CYC     = 500;
    localparam int HOLD_AFTER   = 200;

    typedef struct packed {
        logic [MIN_W-1:0] minute;
        logic [HLT_W-1:0] health;
    } t_reading;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic             night;
        logic             changed;
    } t_backlight;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    sbs_req_if req_if ();
    sbs_rsp_if rsp_if ();

    solar_brightness_scheduler uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req_if   (req_if),
        .o_rsp_if   (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Local copy of the schedule registers and the last applied level
    logic [SUN_W-1:0]  sunrise_r;
    logic [SUN_W-1:0]  sunset_r;
    logic [FADE_W-1:0] fade_r;
    logic [LVL_W-1:0]  day_r;
    logic [LVL_W-1:0]  night_r;
    logic [LVL_W-1:0]  dflt_r;
    logic [LVL_W-1:0]  shown_level;

    t_reading   clock_readings[$];
    t_backlight backlight_due[$];

    int  n_sent = 0;
    int  n_rcvd = 0;
    int  n_settings = 0;
    int  errors = 0;
    int  cycles = 0;
    int  src_wait = 0;
    int  snk_wait = 0;
    bit  quiet_src = 0;
    bit  quiet_snk = 0;
    logic rx_hold = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        req_if.valid         = 1'b0;
        req_if.minute_of_day = '0;
        req_if.health        = '0;
        rsp_if.ready         = 1'b0;
    end

    // Level and night flag for one reading under the current registers
    function automatic t_backlight calc_backlight(input t_reading rd);
        t_backlight bl;
        int s, t, f, m, lvl, lo, hi;
        s  = $signed(sunrise_r);
        t  = $signed(sunset_r);
        f  = int'(fade_r);
        m  = int'(rd.minute);
        lo = int'(night_r);
        hi = int'(day_r);
        bl.night   = 1'b0;
        bl.changed = 1'b0;
        if (f > 0 && m >= s - f && m < s) begin
            lvl = lo + ((hi - lo) * (m - s + f)) / f;
        end else if (m >= s && m < t) begin
            lvl = hi;
        end else if (f > 0 && m >= t && m < t + f) begin
            lvl = hi + ((lo - hi) * (m - t)) / f;
        end else begin
            lvl = lo;
            bl.night = 1'b1;
        end
        if (rd.health == HEALTH_CRIT) begin
            if (lvl > int'(CRIT_CAP)) lvl = int'(CRIT_CAP);
        end else if (rd.health == HEALTH_WARN) begin
            lvl = int'(dflt_r);
        end
        bl.level = 8'(lvl);
        return bl;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Request driver: presents the oldest pending reading
    always @(posedge clk) begin : drive
        t_reading   rd;
        t_backlight bl;
        logic       nv;
        if (!rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            nv = req_if.valid;
            if (req_if.valid && req_if.ready) begin
                rd = clock_readings.pop_front();
                bl = calc_backlight(rd);
                bl.changed  = (bl.level != shown_level);
                shown_level = bl.level;
                backlight_due.push_back(bl);
                n_sent <= n_sent + 1;
                src_wait = quiet_src ? 0 : pick_gap();
                nv = 1'b0;
            end
            if (!nv) begin
                if (src_wait > 0) begin
                    src_wait--;
                end else if (clock_readings.size() > 0) begin
                    nv = 1'b1;
                    req_if.minute_of_day <= clock_readings[0].minute;
                    req_if.health        <= clock_readings[0].health;
                end
            end
            req_if.valid <= nv;
        end
    end

    task automatic note_mismatch(input string what, input int want, input int got);
        if (errors < PRINT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        errors++;
    endtask

    // Result monitor: compares each result with the oldest prediction
    always @(posedge clk) begin : watch
        t_backlight want;
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                n_rcvd <= n_rcvd + 1;
                if (backlight_due.size() == 0) begin
                    if (errors < PRINT_LIMIT)
                        $display("%0t: unexpected result, expected none, actual level %0d",
                                 $time, rsp_if.level);
                    errors++;
                end else begin
                    want = backlight_due.pop_front();
                    if (rsp_if.level !== want.level)
                        note_mismatch("level", want.level, rsp_if.level);
                    if (rsp_if.night !== want.night)
                        note_mismatch("night", want.night, rsp_if.night);
                    if (rsp_if.changed !== want.changed)
                        note_mismatch("changed", want.changed, rsp_if.changed);
                end
                snk_wait = quiet_snk ? 0 : pick_gap();
            end else if (snk_wait > 0) begin
                snk_wait--;
            end
            rsp_if.ready <= !rx_hold && snk_wait == 0;
        end
    end

    // Long receiver hold-off so the block backs up into the request side
    initial begin
        while (n_sent < HOLD_AFTER) @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, backlight_due.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            REG_SUNRISE: sunrise_r = data[SUN_W-1:0];
            REG_SUNSET:  sunset_r  = data[SUN_W-1:0];
            REG_FADE:    fade_r    = data[FADE_W-1:0];
            REG_DAY:     day_r     = data[LVL_W-1:0];
            REG_NIGHT:   night_r   = data[LVL_W-1:0];
            REG_DFLT:    dflt_r    = data[LVL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_cfg(input int sr, input int ss, input int fd,
                             input int dy, input int nt, input int df);
        set_reg(REG_SUNRISE, sr);
        set_reg(REG_SUNSET, ss);
        set_reg(REG_FADE, fd & 8'hFF);
        set_reg(REG_DAY, dy & 8'hFF);
        set_reg(REG_NIGHT, nt & 8'hFF);
        set_reg(REG_DFLT, df & 8'hFF);
        @(posedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic add_reading(input int minute, input logic [HLT_W-1:0] health);
        t_reading rd;
        rd.minute = MIN_W'(minute);
        rd.health = health;
        clock_readings.push_back(rd);
    endtask

    // Wait for every result, then for the pipeline to go quiet
    task automatic settle();
        while (clock_readings.size() != 0 || backlight_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic logic [HLT_W-1:0] rand_health();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return HEALTH_OK;
        if (r < 78) return HEALTH_WARN;
        if (r < 93) return HEALTH_CRIT;
        return HEALTH_SPARE;
    endfunction

    // Minutes mostly around the ramps and the day, some anywhere in the field
    function automatic int rand_minute();
        int r, s, t, f, lo, hi;
        s = $signed(sunrise_r);
        t = $signed(sunset_r);
        f = int'(fade_r);
        r = $urandom_range(0, 99);
        if (r < 65) begin
            lo = s - f - 5;
            hi = ((t > s) ? t : s) + f + 5;
            if (lo < 0) lo = 0;
            if (hi > 2047) hi = 2047;
            if (lo <= hi) return $urandom_range(lo, hi);
            return $urandom_range(0, 2047);
        end
        if (r < 90) return $urandom_range(0, 1439);
        return $urandom_range(0, 2047);
    endfunction

    function automatic int rand_level();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 255;
        return $urandom_range(0, 255);
    endfunction

    task automatic random_cfg();
        int r, sr, ss, fd;
        r = $urandom_range(0, 9);
        if (r == 0)      sr = -6000;
        else if (r == 1) sr = $urandom_range(0, 16383) - 8192;
        else if (r == 2) sr = 1439;
        else             sr = $urandom_range(0, 1439);
        r = $urandom_range(0, 9);
        if (sr == -6000 && r < 5) ss = -6000;
        else if (r < 2)           ss = $urandom_range(0, 16383) - 8192;
        else if (r == 2)          ss = 1439;
        else                      ss = sr + $urandom_range(0, 900);
        r = $urandom_range(0, 9);
        if (r == 0)      fd = 0;
        else if (r == 1) fd = 240;
        else if (r == 2) fd = 255;
        else if (r == 3) fd = 1;
        else             fd = $urandom_range(1, 120);
        apply_cfg(sr, ss, fd, rand_level(), rand_level(), rand_level());
    endtask

    // Main sequence
    initial begin
        sunrise_r   = RST_SUN;
        sunset_r    = RST_SUN;
        fade_r      = RST_FADE;
        day_r       = RST_DAY;
        night_r     = RST_NIGHT;
        dflt_r      = RST_DFLT;
        shown_level = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings, no sun data: everything is full night
        add_reading(0, HEALTH_OK);
        add_reading(2047, HEALTH_SPARE);
        settle();

        // Typical day: ramp edges, day edges, health overrides
        apply_cfg(360, 1080, 30, 200, 20, 100);
        add_reading(330, HEALTH_OK);
        add_reading(345, HEALTH_OK);
        add_reading(359, HEALTH_OK);
        add_reading(360, HEALTH_OK);
        add_reading(1079, HEALTH_OK);
        add_reading(1080, HEALTH_OK);
        add_reading(1095, HEALTH_OK);
        add_reading(1109, HEALTH_OK);
        add_reading(1110, HEALTH_OK);
        add_reading(0, HEALTH_OK);
        add_reading(1439, HEALTH_OK);
        add_reading(720, HEALTH_WARN);
        add_reading(720, HEALTH_CRIT);
        add_reading(340, HEALTH_CRIT);
        add_reading(720, HEALTH_SPARE);
        settle();

        // Zero fade, day darker than night
        apply_cfg(360, 1080, 0, 5, 250, 77);
        add_reading(359, HEALTH_OK);
        add_reading(360, HEALTH_OK);
        add_reading(1080, HEALTH_OK);
        settle();

        // Sunset before sunrise: ramps overlap, sunrise ramp wins
        apply_cfg(600, 560, 60, 0, 255, 0);
        add_reading(550, HEALTH_OK);
        add_reading(570, HEALTH_OK);
        add_reading(610, HEALTH_OK);
        add_reading(620, HEALTH_OK);
        settle();

        // Random phases, the first two at the register extremes
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 0)      apply_cfg(1439, 8191, 255, 255, 255, 255);
            else if (p == 1) apply_cfg(-8192, -8192, 0, 0, 0, 0);
            else             random_cfg();
            quiet_src = (p % 4 == 2);
            quiet_snk = (p % 5 == 3);
            for (int k = 0; k < PHASE_ITEMS; k++)
                add_reading(rand_minute(), rand_health());
            settle();
        end

        $display("Run covered %0d requests and %0d results over %0d register settings,",
                 n_sent, n_rcvd, n_settings);
        $display("including no-sun, zero-fade, overlapping-ramp and full-width register cases.");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule
